// File: design/bmc_pkg.sv
// shared types and constants for the bus memory card
`default_nettype none

package bmc_pkg;

    // bus operation codes
    typedef enum logic [2:0] {
        OP_FETCH   = 3'd0,
        OP_READ    = 3'd1,
        OP_WRITE   = 3'd2,
        OP_OBSERVE = 3'd3,
        OP_LOAD    = 3'd4
    } op_t;

    // access mode register codes
    typedef enum logic [1:0] {
        MODE_ROM     = 2'd0,
        MODE_RAM     = 2'd1,
        MODE_OVERLAY = 2'd2,
        MODE_ROM_ALT = 2'd3
    } mode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ACCESS_MODE = 2'd0,
        CFG_CARD_IS_4K  = 2'd1,
        CFG_SELECTION   = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    // where a read result comes from
    typedef enum logic [1:0] {
        SRC_ZERO    = 2'd0,
        SRC_MAIN    = 2'd1,
        SRC_OVERLAY = 2'd2
    } src_t;

    localparam int unsigned ADDR_W     = 14;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned OFF_W      = 12;
    localparam int unsigned PAGE_W     = 8;
    localparam int unsigned PAGE_BYTES = 256;

    localparam logic [ADDR_W-1:0] CARD_BYTES_2K = 14'd2048;
    localparam logic [ADDR_W-1:0] CARD_BYTES_4K = 14'd4096;
    localparam logic [DATA_W-1:0] BOOT_OPCODE   = 8'h05;

endpackage

`default_nettype wire

// File: design/bus_memory_card_with_boot_overlay.sv
// top level of the bus memory card with boot rom overlay
`default_nettype none

// Memory card on a 14-bit bus. Each s_ transaction is one bus cycle (fetch, data
// read, write, observe of a fetched byte, or load) and yields exactly one m_
// transaction carrying card_selected and read_byte. The card answers when address
// bits 13:12 match selection_bits[2:1] and, in 2K mode, bit 11 matches
// selection_bits[0]. Main RAM and the 256-byte overlay ROM are synchronous
// memories with one write port and one registered read port. Reads are issued
// when the transaction is accepted; the data is registered alongside the result
// stage, then moves to the output register. Writes and loads go to memory in the
// accept cycle, so a following read of the same byte already sees the new value.
// A new transaction can be accepted every clock as long as the output side keeps
// draining. After reset the card runs a clearing pass that zeroes one RAM byte per
// clock (the overlay is zeroed alongside); s_ready stays low during that pass
// while configuration writes are taken as usual. cfg_ready is always high.

module bus_memory_card_with_boot_overlay
    import bmc_pkg::*;
#(
    parameter int unsigned MEMORY_BYTES = 4096
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [2:0]         cfg_data,

    // bus cycle input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_operation,
    input  wire logic [13:0]        s_bus_address,
    input  wire logic [7:0]         s_data_in,

    // result output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_card_selected,
    output logic [7:0]              m_read_byte
);

    localparam int unsigned AW = $clog2(MEMORY_BYTES);
    localparam logic [ADDR_W-1:0] MEM_LIMIT = ADDR_W'(MEMORY_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEMORY_BYTES - 1);

    // configuration registers
    mode_t                  mode_reg, mode_next;
    logic                   card_4k_reg, card_4k_next;
    logic [2:0]             sel_bits_reg, sel_bits_next;

    // overlay latch, cleared until reset by a boot opcode observed in overlay mode
    logic                   ovl_active_reg, ovl_active_next;

    // clearing pass after reset
    logic                   clearing_reg, clearing_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;

    // result stage (memory read in flight)
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_sel_reg, s1_sel_next;
    src_t                   s1_src_reg, s1_src_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic                   m_sel_reg, m_sel_next;
    logic [DATA_W-1:0]      m_byte_reg, m_byte_next;

    // memories and their registered read data
    logic [DATA_W-1:0]      main_mem [MEMORY_BYTES];
    logic [DATA_W-1:0]      ovl_mem [PAGE_BYTES];
    logic [DATA_W-1:0]      main_rdata_reg;
    logic [DATA_W-1:0]      ovl_rdata_reg;

    // handshake
    logic                   accept;
    logic                   out_load;

    // access decode
    op_t                    op;
    logic                   addressed;
    logic [OFF_W-1:0]       offset;
    logic                   off_in_mem;
    logic                   off_in_page;
    logic                   load_in_card;
    logic                   load_in_page;
    logic [ADDR_W-1:0]      card_bytes;

    logic                   acc_sel;
    src_t                   acc_src;
    logic                   acc_wr_main;
    logic [AW-1:0]          acc_main_addr;
    logic                   acc_wr_ovl;
    logic [PAGE_W-1:0]      acc_ovl_addr;
    logic                   acc_boot_seen;

    // memory port controls
    logic                   main_we;
    logic [AW-1:0]          main_waddr;
    logic [DATA_W-1:0]      main_wdata;
    logic                   ovl_we;
    logic [PAGE_W-1:0]      ovl_waddr;
    logic [DATA_W-1:0]      ovl_wdata;

    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_card_selected = m_sel_reg;
    assign m_read_byte     = m_byte_reg;

    // output register takes the result stage when it is empty or being drained
    assign out_load = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !clearing_reg && (!s1_valid_reg || out_load);
    assign accept   = s_valid && s_ready;

    // address decode
    assign op         = op_t'(s_operation);
    assign addressed  = (s_bus_address[13:12] == sel_bits_reg[2:1])
                     && (card_4k_reg || (s_bus_address[11] == sel_bits_reg[0]));
    assign offset     = card_4k_reg ? s_bus_address[OFF_W-1:0]
                                    : {1'b0, s_bus_address[10:0]};
    assign off_in_mem  = ({{(ADDR_W-OFF_W){1'b0}}, offset} < MEM_LIMIT);
    assign off_in_page = (offset < OFF_W'(PAGE_BYTES));
    assign card_bytes  = card_4k_reg ? CARD_BYTES_4K : CARD_BYTES_2K;
    assign load_in_card = (s_bus_address < card_bytes) && (s_bus_address < MEM_LIMIT);
    assign load_in_page = (s_bus_address < ADDR_W'(PAGE_BYTES));

    // per-operation action
    always_comb begin
        acc_sel       = 1'b0;
        acc_src       = SRC_ZERO;
        acc_wr_main   = 1'b0;
        acc_main_addr = offset[AW-1:0];
        acc_wr_ovl    = 1'b0;
        acc_ovl_addr  = s_bus_address[PAGE_W-1:0];
        acc_boot_seen = 1'b0;
        unique case (op)
            OP_FETCH, OP_READ: begin
                if (addressed) begin
                    acc_sel = 1'b1;
                    // page zero comes from the overlay until the boot opcode is seen
                    if (mode_reg == MODE_OVERLAY && ovl_active_reg && off_in_page) begin
                        acc_src = SRC_OVERLAY;
                    end else if (off_in_mem) begin
                        acc_src = SRC_MAIN;
                    end
                end
            end
            OP_WRITE: begin
                // rom modes drop writes; overlay mode writes land in ram
                if (addressed && (mode_reg == MODE_RAM || mode_reg == MODE_OVERLAY)
                        && off_in_mem) begin
                    acc_wr_main = 1'b1;
                    acc_sel     = 1'b1;
                end
            end
            OP_OBSERVE: begin
                // address is not decoded for the boot opcode watch
                acc_boot_seen = (mode_reg == MODE_OVERLAY) && (s_data_in == BOOT_OPCODE);
            end
            OP_LOAD: begin
                acc_main_addr = s_bus_address[AW-1:0];
                if (mode_reg == MODE_OVERLAY) begin
                    if (load_in_page) begin
                        acc_wr_ovl = 1'b1;
                        acc_sel    = 1'b1;
                    end
                end else if (load_in_card) begin
                    acc_wr_main = 1'b1;
                    acc_sel     = 1'b1;
                end
            end
            default: begin
                // unused operation codes do nothing
            end
        endcase
    end

    // memory write ports: clearing pass has the port until it finishes
    always_comb begin
        if (clearing_reg) begin
            main_we    = 1'b1;
            main_waddr = clr_addr_reg;
            main_wdata = '0;
            ovl_we     = (clr_addr_reg < AW'(PAGE_BYTES));
            ovl_waddr  = clr_addr_reg[PAGE_W-1:0];
            ovl_wdata  = '0;
        end else begin
            main_we    = accept && acc_wr_main;
            main_waddr = acc_main_addr;
            main_wdata = s_data_in;
            ovl_we     = accept && acc_wr_ovl;
            ovl_waddr  = acc_ovl_addr;
            ovl_wdata  = s_data_in;
        end
    end

    // main ram, one write and one registered read
    always_ff @(posedge aclk) begin
        if (main_we) begin
            main_mem[main_waddr] <= main_wdata;
        end
        if (accept && acc_src == SRC_MAIN) begin
            main_rdata_reg <= main_mem[offset[AW-1:0]];
        end
    end

    // overlay rom image
    always_ff @(posedge aclk) begin
        if (ovl_we) begin
            ovl_mem[ovl_waddr] <= ovl_wdata;
        end
        if (accept && acc_src == SRC_OVERLAY) begin
            ovl_rdata_reg <= ovl_mem[offset[PAGE_W-1:0]];
        end
    end

    // next state
    always_comb begin
        mode_next       = mode_reg;
        card_4k_next    = card_4k_reg;
        sel_bits_next   = sel_bits_reg;
        ovl_active_next = ovl_active_reg;
        clearing_next   = clearing_reg;
        clr_addr_next   = clr_addr_reg;
        s1_valid_next   = s1_valid_reg;
        s1_sel_next     = s1_sel_reg;
        s1_src_next     = s1_src_reg;
        m_valid_next    = m_valid_reg;
        m_sel_next      = m_sel_reg;
        m_byte_next     = m_byte_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ACCESS_MODE: mode_next     = mode_t'(cfg_data[1:0]);
                CFG_CARD_IS_4K:  card_4k_next  = cfg_data[0];
                CFG_SELECTION:   sel_bits_next = cfg_data;
                default: begin
                    // writes beyond the register list are ignored
                end
            endcase
        end

        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == CLR_LAST) begin
                clearing_next = 1'b0;
            end
        end

        if (accept && acc_boot_seen) begin
            ovl_active_next = 1'b0;
        end

        // result stage
        if (accept) begin
            s1_valid_next = 1'b1;
            s1_sel_next   = acc_sel;
            s1_src_next   = acc_src;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end

        // output register
        if (out_load) begin
            m_valid_next = 1'b1;
            m_sel_next   = s1_sel_reg;
            unique case (s1_src_reg)
                SRC_MAIN:    m_byte_next = main_rdata_reg;
                SRC_OVERLAY: m_byte_next = ovl_rdata_reg;
                default:     m_byte_next = '0;
            endcase
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_RAM;
            card_4k_reg    <= 1'b0;
            sel_bits_reg   <= '0;
            ovl_active_reg <= 1'b1;
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            card_4k_reg    <= card_4k_next;
            sel_bits_reg   <= sel_bits_next;
            ovl_active_reg <= ovl_active_next;
            clearing_reg   <= clearing_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s1_sel_reg <= s1_sel_next;
        s1_src_reg <= s1_src_next;
        m_sel_reg  <= m_sel_next;
        m_byte_reg <= m_byte_next;
    end

endmodule

`default_nettype wire
